// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Each check runs on the rising clock edge and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ----- src/u2u8_pkg.sv -----
package u2u8_pkg;

  // Source modes; the codes above the last one behave as pass-through.
  typedef enum logic [2:0] {
    MODE_PASS  = 3'd0,
    MODE_U16LE = 3'd1,
    MODE_U16BE = 3'd2,
    MODE_U32LE = 3'd3,
    MODE_U32BE = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_SOURCE_MODE = 1'b0,
    REG_MARK_SKIP   = 1'b1
  } reg_index_t;

  localparam int CfgW = 3;

  // Code unit and code point limits.
  localparam logic [15:0] SurrHighMin = 16'hD800;
  localparam logic [15:0] SurrHighMax = 16'hDBFF;
  localparam logic [15:0] SurrLowMin  = 16'hDC00;
  localparam logic [15:0] SurrLowMax  = 16'hDFFF;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [31:0] MaxCodePt   = 32'h10FFFF;

  // Replacement character U+FFFD as UTF-8.
  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  // Lead and continuation markers.
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] ContMark  = 8'h80;

  // Job queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCountW    = $clog2(QueueDepth + 1);

  // Most output bytes one input byte can cause.
  localparam int MaxResults = 6;
  localparam int IdxW       = $clog2(MaxResults);

  // What a queued point turns into.
  typedef enum logic [1:0] {
    PT_RAW  = 2'd0,
    PT_CODE = 2'd1,
    PT_REPL = 2'd2
  } point_kind_t;

  typedef struct packed {
    point_kind_t kind;
    logic [20:0] value;
  } point_t;

  // One classified input byte: up to two points to encode, plus end flags.
  typedef struct packed {
    logic   p0_valid;
    logic   p1_valid;
    point_t p0;
    point_t p1;
    logic   eoi;
    logic   err;
  } job_t;

  // Number of UTF-8 bytes a point becomes.
  function automatic logic [2:0] point_byte_count(point_t p);
    logic [2:0] len;
    case (p.kind)
      PT_RAW:  len = 3'd1;
      PT_REPL: len = 3'd3;
      PT_CODE: begin
        if (p.value < 21'h80)           len = 3'd1;
        else if (p.value < 21'h800)     len = 3'd2;
        else if (p.value < SuppBase)    len = 3'd3;
        else                            len = 3'd4;
      end
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  // Byte k of the UTF-8 form of a point.
  function automatic logic [7:0] utf8_byte(point_t p, logic [1:0] k);
    logic [7:0]  b;
    logic [20:0] v;
    v = p.value;
    b = 8'h00;
    case (p.kind)
      PT_RAW:  b = v[7:0];
      PT_REPL: begin
        case (k)
          2'd0:    b = ReplByte0;
          2'd1:    b = ReplByte1;
          default: b = ReplByte2;
        endcase
      end
      PT_CODE: begin
        if (v < 21'h80) begin
          b = {1'b0, v[6:0]};
        end else if (v < 21'h800) begin
          if (k == 2'd0) b = LeadTwo | {3'b000, v[10:6]};
          else           b = ContMark | (ContMask & {2'b00, v[5:0]});
        end else if (v < SuppBase) begin
          case (k)
            2'd0:    b = LeadThree | {4'b0000, v[15:12]};
            2'd1:    b = ContMark | {2'b00, v[11:6]};
            default: b = ContMark | {2'b00, v[5:0]};
          endcase
        end else begin
          case (k)
            2'd0:    b = LeadFour | {5'b00000, v[20:18]};
            2'd1:    b = ContMark | {2'b00, v[17:12]};
            2'd2:    b = ContMark | {2'b00, v[11:6]};
            default: b = ContMark | {2'b00, v[5:0]};
          endcase
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/utf16_utf32_to_utf8_transcoder.sv -----
// Transcodes a byte stream of UTF-16 or UTF-32 text (either byte order) into UTF-8, or
// passes bytes through unchanged, after dropping a configured number of leading byte-order
// mark bytes. One input byte is accepted per cycle whenever the four-entry job queue has
// room; the output side delivers one UTF-8 byte per cycle while the receiver is ready, and
// an input byte yields as many output bytes as its points need: none for a dropped mark
// byte or an unfinished code unit, one in pass-through, up to six when a held high
// surrogate is flushed next to a new unit. A stream ends on an input with tlast; its final
// result carries the done flag and, if a partial code unit was left over, the length
// error flag. Configure only while the block is idle; writing the source mode discards
// any partial unit.
module utf16_utf32_to_utf8_transcoder
  import u2u8_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // Configuration write port
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  // Source bytes
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] in_byte
  input  logic            s_axis_tlast,   // end_of_input
  // UTF-8 bytes
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] utf8_byte
  output logic            m_axis_tlast,   // run_last
  output logic [2:0]      m_axis_tuser    // [0] byte_present, [1] stream_done, [2] length_error
);

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head_job;

  // Front: byte assembly, surrogate pairing and classification.
  u2u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Job queue decoupling the two sides.
  u2u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Back: UTF-8 byte emission.
  u2u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_flags  (m_axis_tuser)
  );

endmodule

// ----- src/u2u8_front.sv -----
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [2:0]  source_mode;
  logic [2:0]  mark_skip_count;
  logic [23:0] unit_bytes, unit_bytes_next;
  logic [1:0]  unit_position, unit_position_next;
  logic [9:0]  held_high, held_high_next;
  logic        pending, pending_next;
  logic [2:0]  dropped, dropped_next;

  logic        fire;
  logic        is_pass, is_u16, unit_done;
  logic [31:0] full_word, word32;
  logic [15:0] cu;
  logic        cu_low, cu_high;
  point_t      pa, pb, pf;
  logic        va, vb, vf;
  logic        err;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Classify the byte and work out the points it completes.
  always_comb begin
    unit_bytes_next    = unit_bytes;
    unit_position_next = unit_position;
    held_high_next     = held_high;
    pending_next       = pending;
    dropped_next       = dropped;
    pa = '0;
    pb = '0;
    pf = '0;
    va = 1'b0;
    vb = 1'b0;
    vf = 1'b0;
    err = 1'b0;

    is_pass = !(source_mode inside {MODE_U16LE, MODE_U16BE, MODE_U32LE, MODE_U32BE});
    is_u16  = (source_mode == MODE_U16LE) || (source_mode == MODE_U16BE);
    unit_done = is_u16 ? (unit_position == 2'd1) : (unit_position == 2'd3);
    full_word = {unit_bytes, in_byte};
    cu = (source_mode == MODE_U16LE) ? {full_word[7:0], full_word[15:8]} : full_word[15:0];
    word32 = (source_mode == MODE_U32LE) ?
             {full_word[7:0], full_word[15:8], full_word[23:16], full_word[31:24]} :
             full_word;
    cu_low  = (cu >= SurrLowMin) && (cu <= SurrLowMax);
    cu_high = (cu >= SurrHighMin) && (cu <= SurrHighMax);

    if (dropped < mark_skip_count) begin
      dropped_next = dropped + 3'd1;
    end else if (is_pass) begin
      va = 1'b1;
      pa.kind  = PT_RAW;
      pa.value = {13'd0, in_byte};
    end else if (!unit_done) begin
      unit_bytes_next    = full_word[23:0];
      unit_position_next = unit_position + 2'd1;
    end else begin
      unit_bytes_next    = '0;
      unit_position_next = '0;
      if (is_u16) begin
        if (pending && cu_low) begin
          // Surrogate pair joins into one supplementary code point.
          pending_next = 1'b0;
          va = 1'b1;
          pa.kind  = PT_CODE;
          pa.value = SuppBase + {1'b0, held_high, cu[9:0]};
        end else begin
          if (pending) begin
            // Unpaired high surrogate goes out on its own.
            va = 1'b1;
            pa.kind  = PT_CODE;
            pa.value = {5'd0, SurrHighMin[15:10], held_high};
          end
          if (cu_high) begin
            pending_next   = 1'b1;
            held_high_next = cu[9:0];
          end else begin
            pending_next = 1'b0;
            vb = 1'b1;
            pb.kind  = PT_CODE;
            pb.value = {5'd0, cu};
          end
        end
      end else begin
        va = 1'b1;
        if (word32 <= MaxCodePt) begin
          pa.kind  = PT_CODE;
          pa.value = word32[20:0];
        end else begin
          pa.kind  = PT_REPL;
          pa.value = '0;
        end
      end
    end

    // End of stream flushes a held surrogate and restarts all counting.
    if (in_last) begin
      err = unit_position_next != 2'd0;
      if (pending_next) begin
        vf = 1'b1;
        pf.kind  = PT_CODE;
        pf.value = {5'd0, SurrHighMin[15:10], held_high_next};
      end
      unit_bytes_next    = '0;
      unit_position_next = '0;
      held_high_next     = '0;
      pending_next       = 1'b0;
      dropped_next       = '0;
    end
  end

  // Pack the points in order into the job.
  always_comb begin
    q_job = '0;
    q_job.eoi = in_last;
    q_job.err = err;
    if (va) begin
      q_job.p0_valid = 1'b1;
      q_job.p0       = pa;
      q_job.p1_valid = vb || vf;
      q_job.p1       = vb ? pb : pf;
    end else if (vb) begin
      q_job.p0_valid = 1'b1;
      q_job.p0       = pb;
      q_job.p1_valid = vf;
      q_job.p1       = pf;
    end else begin
      q_job.p0_valid = vf;
      q_job.p0       = pf;
    end
  end

  assign q_push = fire && (va || vb || vf || in_last);

  // Configuration and decoding state.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode     <= MODE_PASS;
      mark_skip_count <= '0;
      unit_bytes      <= '0;
      unit_position   <= '0;
      held_high       <= '0;
      pending         <= 1'b0;
      dropped         <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SOURCE_MODE) begin
        source_mode   <= cfg_data;
        unit_bytes    <= '0;
        unit_position <= '0;
        held_high     <= '0;
        pending       <= 1'b0;
      end else begin
        mark_skip_count <= cfg_data;
      end
    end else if (fire) begin
      unit_bytes    <= unit_bytes_next;
      unit_position <= unit_position_next;
      held_high     <= held_high_next;
      pending       <= pending_next;
      dropped       <= dropped_next;
    end
  end

endmodule

// ----- src/u2u8_queue.sv -----
`include "assert_macros.svh"

module u2u8_queue
  import u2u8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t               entries [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCountW-1:0] count;

  assign full       = count == QCountW'(QueueDepth);
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + QPtrW'(1);
      if (push && !pop)      count <= count + QCountW'(1);
      else if (pop && !push) count <= count - QCountW'(1);
    end
  end

  `ASSERT_NEVER(q_overflow, clk, rst, push && full && !pop, "job pushed into a full queue")
  `ASSERT_NEVER(q_underflow, clk, rst, pop && !head_valid, "job popped from an empty queue")

endmodule

// ----- src/u2u8_back.sv -----
`include "assert_macros.svh"

module u2u8_back
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [2:0] out_flags
);

  logic [IdxW-1:0] idx;
  logic [2:0]      len0, len1;
  logic [3:0]      total;
  logic [2:0]      rel;
  logic [7:0]      cur_byte;
  logic            bare, last, load;
  logic            out_present, out_done, out_err;

  // Pick the byte at the current position of the head job.
  always_comb begin
    len0  = head_job.p0_valid ? point_byte_count(head_job.p0) : 3'd0;
    len1  = head_job.p1_valid ? point_byte_count(head_job.p1) : 3'd0;
    total = {1'b0, len0} + {1'b0, len1};
    bare  = head_job.eoi && (total == 4'd0);
    rel   = idx - len0;
    if (idx < len0) cur_byte = utf8_byte(head_job.p0, idx[1:0]);
    else            cur_byte = utf8_byte(head_job.p1, rel[1:0]);
    if (bare) cur_byte = 8'h00;
    last = bare || (({1'b0, idx} + 4'd1) == total);
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last;

  // Byte position within the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last ? '0 : idx + IdxW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= cur_byte;
      out_last    <= last;
      out_present <= !bare;
      out_done    <= last && head_job.eoi;
      out_err     <= last && head_job.err;
    end
  end

  assign out_flags = {out_err, out_done, out_present};

  `ASSERT_NEVER(b_idx_range, clk, rst, head_valid && (idx >= IdxW'(MaxResults)), "byte index out of range")
  `ASSERT_PROP(b_done_last, clk, rst, out_valid && out_done |-> out_last, "stream end not on last byte")
  `ASSERT_PROP(b_err_done, clk, rst, out_valid && out_err |-> out_done, "length error without stream end")

endmodule

// ----- verif/transcode_checker.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the transcoder, predicts the
// UTF-8 requests that each accepted source byte should cause and compares them in order.
module transcode_checker
  import u2u8_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            s_axis_tvalid,
  input  logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] in_byte
  input  logic            s_axis_tlast,   // end_of_input
  input  logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  logic [7:0]      m_axis_tdata,   // [7:0] utf8_byte
  input  logic            m_axis_tlast,   // run_last
  input  logic [2:0]      m_axis_tuser,   // [0] byte_present, [1] stream_done, [2] length_error
  output int              error_count,
  output int              pending_count,
  output int              checked_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       present;
    logic       done;
    logic       err;
  } utf8_result_t;

  // Expected requests in order, and the bytes produced by the current source byte.
  utf8_result_t utf8_expected[$];
  logic [7:0]   utf8_bytes[$];
  utf8_result_t want;

  // Shadow copy of the registers and the decoder state.
  logic [2:0]  src_mode;
  logic [2:0]  skip_count;
  logic [23:0] unit_bytes;
  logic [1:0]  unit_pos;
  logic [9:0]  held_high;
  logic        high_held;
  logic [2:0]  mark_dropped;

  int errors  = 0;
  int checked = 0;

  function automatic void clear_units();
    unit_bytes = '0;
    unit_pos   = '0;
    held_high  = '0;
    high_held  = 1'b0;
  endfunction

  // Appends the UTF-8 form of one code point; anything past the Unicode range
  // becomes the replacement character.
  function automatic void emit_point(logic [31:0] cp);
    if (cp < 32'h80) begin
      utf8_bytes.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      utf8_bytes.push_back(LeadTwo | {3'b000, cp[10:6]});
      utf8_bytes.push_back(ContMark | {2'b00, cp[5:0]});
    end else if (cp < 32'(SuppBase)) begin
      utf8_bytes.push_back(LeadThree | {4'b0000, cp[15:12]});
      utf8_bytes.push_back(ContMark | {2'b00, cp[11:6]});
      utf8_bytes.push_back(ContMark | {2'b00, cp[5:0]});
    end else if (cp <= MaxCodePt) begin
      utf8_bytes.push_back(LeadFour | {5'b00000, cp[20:18]});
      utf8_bytes.push_back(ContMark | {2'b00, cp[17:12]});
      utf8_bytes.push_back(ContMark | {2'b00, cp[11:6]});
      utf8_bytes.push_back(ContMark | {2'b00, cp[5:0]});
    end else begin
      utf8_bytes.push_back(ReplByte0);
      utf8_bytes.push_back(ReplByte1);
      utf8_bytes.push_back(ReplByte2);
    end
  endfunction

  // A held high surrogate either pairs with a low one or is flushed on its own.
  function automatic void take_utf16(logic [15:0] cu);
    if (high_held) begin
      high_held = 1'b0;
      if (cu >= SurrLowMin && cu <= SurrLowMax) begin
        emit_point(32'(SuppBase) + {12'd0, held_high, cu[9:0]});
        return;
      end
      emit_point({16'd0, SurrHighMin | {6'd0, held_high}});
    end
    if (cu >= SurrHighMin && cu <= SurrHighMax) begin
      held_high = cu[9:0];
      high_held = 1'b1;
    end else begin
      emit_point({16'd0, cu});
    end
  endfunction

  // Gathers bytes into a code unit and decodes it once complete.
  function automatic void take_unit_byte(logic [7:0] b);
    logic [31:0] full;
    logic [1:0]  final_pos;
    full      = {unit_bytes, b};
    final_pos = (src_mode == MODE_U16LE || src_mode == MODE_U16BE) ? 2'd1 : 2'd3;
    if (unit_pos < final_pos) begin
      unit_bytes = full[23:0];
      unit_pos   = unit_pos + 2'd1;
      return;
    end
    unit_bytes = '0;
    unit_pos   = '0;
    case (src_mode)
      MODE_U16LE: take_utf16({full[7:0], full[15:8]});
      MODE_U16BE: take_utf16(full[15:0]);
      MODE_U32LE: emit_point({full[7:0], full[15:8], full[23:16], full[31:24]});
      default:    emit_point(full);
    endcase
  endfunction

  // Works out every request caused by one source byte and queues them.
  function automatic void transcode_byte(logic [7:0] b, logic eoi);
    logic         bare;
    logic         short_unit;
    utf8_result_t r;
    bare       = 1'b0;
    short_unit = 1'b0;
    utf8_bytes.delete();
    if (mark_dropped < skip_count) begin
      mark_dropped = mark_dropped + 3'd1;
    end else if (src_mode >= MODE_U16LE && src_mode <= MODE_U32BE) begin
      take_unit_byte(b);
    end else begin
      utf8_bytes.push_back(b);
    end
    // The end of a stream flushes a held surrogate and flags a partial unit.
    if (eoi) begin
      short_unit = (unit_pos != 2'd0);
      if (high_held) emit_point({16'd0, SurrHighMin | {6'd0, held_high}});
      if (utf8_bytes.size() == 0) begin
        bare = 1'b1;
        utf8_bytes.push_back(8'h00);
      end
      clear_units();
      mark_dropped = '0;
    end
    for (int k = 0; k < utf8_bytes.size(); k++) begin
      r.data    = utf8_bytes[k];
      r.present = !bare;
      r.last    = (k == utf8_bytes.size() - 1);
      r.done    = r.last && eoi;
      r.err     = r.last && short_unit;
      utf8_expected.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Requests are retired before new source bytes are predicted; a byte accepted
  // at this edge cannot have produced a result yet.
  always @(posedge clk) begin
    if (rst) begin
      src_mode     = MODE_PASS;
      skip_count   = '0;
      mark_dropped = '0;
      clear_units();
      utf8_expected.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SOURCE_MODE) begin
          src_mode = cfg_data;
          clear_units();
        end else begin
          skip_count = cfg_data;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (utf8_expected.size() == 0) begin
          $error("UTF-8 request with nothing expected: data %0h", m_axis_tdata);
          errors++;
        end else begin
          want = utf8_expected.pop_front();
          checked++;
          check_field("utf8_byte", want.data, m_axis_tdata);
          check_field("run_last", {7'd0, want.last}, {7'd0, m_axis_tlast});
          check_field("byte_present", {7'd0, want.present}, {7'd0, m_axis_tuser[0]});
          check_field("stream_done", {7'd0, want.done}, {7'd0, m_axis_tuser[1]});
          check_field("length_error", {7'd0, want.err}, {7'd0, m_axis_tuser[2]});
        end
      end
      if (s_axis_tvalid && s_axis_tready) transcode_byte(s_axis_tdata, s_axis_tlast);
    end
    error_count   <= errors;
    pending_count <= utf8_expected.size();
    checked_count <= checked;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import u2u8_pkg::*;

  localparam logic [2:0] ModeUndefined = 3'd7;
  localparam int         DrainCycles   = 16;
  localparam int         CycleLimit    = 400000;
  localparam int         RandomItems   = 380;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       cfg_we        = 1'b0;
  logic       cfg_index     = REG_SOURCE_MODE;
  logic [2:0] cfg_data      = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;  // end_of_input
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;  // [7:0] utf8_byte
  logic       m_axis_tlast;  // run_last
  logic [2:0] m_axis_tuser;  // [0] byte_present, [1] stream_done, [2] length_error

  int error_count;
  int pending_count;
  int checked_count;

  logic       steady = 1'b0;
  logic [7:0] src_bytes[$];
  int         mark_len;
  int         sent_count   = 0;
  int         stream_count = 0;
  int         phase_count  = 0;
  int         cycle_count  = 0;

  always #5 clk = ~clk;

  utf16_utf32_to_utf8_transcoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  transcode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // The UTF-8 side stalls at random except during the steady phase.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99, 0) >= 26);
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d requests outstanding.",
               cycle_count, pending_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one source byte, with a random gap before it unless the phase is steady.
  task automatic send_req(input logic [7:0] b, input logic last);
    if (!steady) begin
      while ($urandom_range(99, 0) < 26) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_stream(input logic with_end);
    for (int i = 0; i < src_bytes.size(); i++) begin
      send_req(src_bytes[i], with_end && (i == src_bytes.size() - 1));
    end
    stream_count++;
  endtask

  // Holds the source side off until every expected request has arrived and the
  // block has had time to finish bytes that produce nothing.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [2:0] mode, input logic [2:0] skip);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOURCE_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_index <= REG_MARK_SKIP;
    cfg_data  <= skip;
    @(posedge clk);
    cfg_we    <= 1'b0;
    phase_count++;
  endtask

  function automatic logic [31:0] random_point();
    int r;
    r = $urandom_range(99, 0);
    if (r < 30)      return $urandom_range(32'h7F, 0);
    else if (r < 50) return $urandom_range(32'h7FF, 32'h80);
    else if (r < 70) return $urandom_range(32'hFFFF, 32'h800);
    else if (r < 88) return $urandom_range(32'h10FFFF, 32'h10000);
    else if (r < 93) return $urandom_range(32'hDBFF, 32'hD800);
    else if (r < 97) return $urandom_range(32'hDFFF, 32'hDC00);
    else             return $urandom();
  endfunction

  function automatic void add_unit16(logic [2:0] mode, logic [15:0] u);
    if (mode == MODE_U16LE) begin
      src_bytes.push_back(u[7:0]);
      src_bytes.push_back(u[15:8]);
    end else begin
      src_bytes.push_back(u[15:8]);
      src_bytes.push_back(u[7:0]);
    end
  endfunction

  // Encodes one code point in the source format; supplementary points in UTF-16
  // become a surrogate pair, surrogate values on their own stay unpaired.
  function automatic void add_point(logic [2:0] mode, logic [31:0] cp);
    logic [31:0] v;
    case (mode)
      MODE_U16LE, MODE_U16BE: begin
        if (cp >= 32'(SuppBase) && cp <= MaxCodePt) begin
          v = cp - 32'(SuppBase);
          add_unit16(mode, SurrHighMin | {6'd0, v[19:10]});
          add_unit16(mode, SurrLowMin | {6'd0, v[9:0]});
        end else begin
          add_unit16(mode, cp[15:0]);
        end
      end
      MODE_U32LE: begin
        src_bytes.push_back(cp[7:0]);
        src_bytes.push_back(cp[15:8]);
        src_bytes.push_back(cp[23:16]);
        src_bytes.push_back(cp[31:24]);
      end
      MODE_U32BE: begin
        src_bytes.push_back(cp[31:24]);
        src_bytes.push_back(cp[23:16]);
        src_bytes.push_back(cp[15:8]);
        src_bytes.push_back(cp[7:0]);
      end
      default: src_bytes.push_back(8'($urandom_range(255, 0)));
    endcase
  endfunction

  // A stream is a mark prefix, a few code points and now and then a broken tail.
  function automatic void build_stream(logic [2:0] mode, logic [2:0] skip);
    int r;
    src_bytes.delete();
    mark_len = skip;
    repeat (skip) src_bytes.push_back(8'($urandom_range(255, 0)));
    repeat ($urandom_range(6, 1)) add_point(mode, random_point());
    r = $urandom_range(99, 0);
    if (r < 8 && src_bytes.size() > mark_len + 1) void'(src_bytes.pop_back());
    else if (r < 16) src_bytes.push_back(8'($urandom_range(255, 0)));
  endfunction

  initial begin
    logic [2:0] mode;
    logic [2:0] skip;
    int         streams;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pass-through after reset with both byte extremes.
    src_bytes = '{8'h00, 8'hFF};
    send_stream(1'b1);

    // Big-endian UTF-16 behind a two-byte mark: a valid pair, a held high surrogate
    // flushed beside a three-byte unit, a lone low surrogate, and a high surrogate
    // still held when the stream ends.
    settle();
    write_regs(MODE_U16BE, 3'd2);
    src_bytes = '{8'hFE, 8'hFF, 8'hD8, 8'h3D, 8'hDE, 8'h00, 8'hD8, 8'h00,
                  8'h20, 8'hAC, 8'hDC, 8'h00, 8'hD8, 8'h01};
    send_stream(1'b1);

    // Little-endian UTF-32: an out-of-range value, then a partial unit at the end.
    settle();
    write_regs(MODE_U32LE, 3'd0);
    src_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_stream(1'b1);
    src_bytes = '{8'h41, 8'h00};
    send_stream(1'b1);

    // A mark byte that is also the final byte leaves only an end marker.
    settle();
    write_regs(MODE_U32BE, 3'd1);
    src_bytes = '{8'h5A};
    send_stream(1'b1);

    // Random phases; the second to fifth pin down the register extremes.
    while (sent_count < RandomItems) begin
      case (phase_count)
        4:       begin mode = MODE_U16LE;    skip = 3'd0; end
        5:       begin mode = MODE_U32BE;    skip = 3'd7; end
        6:       begin mode = MODE_PASS;     skip = 3'd4; end
        7:       begin mode = ModeUndefined; skip = 3'd0; end
        default: begin
          if ($urandom_range(99, 0) < 85) begin
            mode = 3'($urandom_range(MODE_U32BE, MODE_U16LE));
          end else begin
            streams = $urandom_range(3, 0);
            mode    = (streams == 0) ? MODE_PASS : 3'(MODE_U32BE + streams);
          end
          skip = ($urandom_range(99, 0) < 80) ? 3'($urandom_range(4, 0))
                                              : 3'($urandom_range(7, 5));
        end
      endcase
      settle();
      steady <= (phase_count == 8);
      write_regs(mode, skip);
      streams = steady ? 8 : $urandom_range(4, 2);
      for (int s = 0; s < streams; s++) begin
        build_stream(mode, skip);
        // The last stream of a phase is sometimes left open across the mode change.
        send_stream((s < streams - 1) || ($urandom_range(9, 0) != 0));
      end
    end

    settle();
    steady <= 1'b0;
    $display("Sent %0d source bytes in %0d streams over %0d register settings.",
             sent_count, stream_count, phase_count);
    $display("Compared %0d UTF-8 requests across pass-through, UTF-16 and UTF-32 in %s",
             checked_count, "both byte orders, with marks, surrogates and short units.");
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/u2u8_pkg.sv
src/u2u8_front.sv
src/u2u8_queue.sv
src/u2u8_back.sv
src/utf16_utf32_to_utf8_transcoder.sv
verif/transcode_checker.sv
verif/tb_top.sv
